/* hdl/sdes_pkg.sv */
// types, constants and cipher functions for the simplified des block
package sdes_pkg;

  localparam int unsigned KeyWidth  = 10;
  localparam int unsigned ByteWidth = 8;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  localparam logic [1:0] REG_CIPHER_KEY   = 2'd0;
  localparam logic [1:0] REG_INIT_VECTOR  = 2'd1;
  localparam logic [1:0] REG_CHAIN_ENABLE = 2'd2;

  typedef struct packed {
    logic                 kind;
    logic [ByteWidth-1:0] data_byte;
    logic                 message_start;
  } in_item_t;

  typedef struct packed {
    logic [ByteWidth-1:0] result_byte;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          index;
    logic [KeyWidth-1:0] value;
  } cfg_item_t;

  // source bit index for each output bit, most significant output bit first
  localparam logic [3:0] P10_TAB [10] = '{4'd7, 4'd5, 4'd8, 4'd3, 4'd6,
                                          4'd0, 4'd9, 4'd1, 4'd2, 4'd4};
  localparam logic [3:0] P8_TAB  [8]  = '{4'd4, 4'd7, 4'd3, 4'd6, 4'd2, 4'd5, 4'd0, 4'd1};
  localparam logic [2:0] IP_TAB  [8]  = '{3'd6, 3'd2, 3'd5, 3'd7, 3'd4, 3'd0, 3'd3, 3'd1};
  localparam logic [2:0] IPI_TAB [8]  = '{3'd4, 3'd7, 3'd5, 3'd3, 3'd1, 3'd6, 3'd0, 3'd2};
  localparam logic [1:0] EP_TAB  [8]  = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0, 2'd3};
  localparam logic [1:0] P4_TAB  [4]  = '{2'd2, 2'd0, 2'd1, 2'd3};

  localparam logic [1:0] SBOX0 [16] = '{2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                        2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
  localparam logic [1:0] SBOX1 [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                        2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

  function automatic logic [9:0] perm_p10(logic [9:0] v);
    logic [9:0] r;
    for (int i = 0; i < 10; i++) begin
      r[9-i] = v[P10_TAB[i]];
    end
    return r;
  endfunction

  function automatic logic [7:0] perm_p8(logic [9:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[P8_TAB[i]];
    end
    return r;
  endfunction

  function automatic logic [7:0] perm_ip(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[IP_TAB[i]];
    end
    return r;
  endfunction

  function automatic logic [7:0] perm_ipi(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[IPI_TAB[i]];
    end
    return r;
  endfunction

  function automatic logic [7:0] perm_ep(logic [3:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[EP_TAB[i]];
    end
    return r;
  endfunction

  function automatic logic [3:0] perm_p4(logic [3:0] v);
    logic [3:0] r;
    for (int i = 0; i < 4; i++) begin
      r[3-i] = v[P4_TAB[i]];
    end
    return r;
  endfunction

  function automatic logic [4:0] rot_left1(logic [4:0] x);
    return {x[3:0], x[4]};
  endfunction

  function automatic logic [4:0] rot_left3(logic [4:0] x);
    return {x[1:0], x[4:2]};
  endfunction

  function automatic logic [7:0] subkey1(logic [KeyWidth-1:0] key);
    logic [9:0] p;
    p = perm_p10(key);
    return perm_p8({rot_left1(p[9:5]), rot_left1(p[4:0])});
  endfunction

  function automatic logic [7:0] subkey2(logic [KeyWidth-1:0] key);
    logic [9:0] p;
    p = perm_p10(key);
    return perm_p8({rot_left3(p[9:5]), rot_left3(p[4:0])});
  endfunction

  function automatic logic [3:0] round_f(logic [3:0] r4, logic [7:0] k);
    logic [7:0] e;
    logic [3:0] s;
    e = perm_ep(r4) ^ k;
    s = {SBOX0[{e[7], e[4], e[6], e[5]}], SBOX1[{e[3], e[0], e[2], e[1]}]};
    return perm_p4(s);
  endfunction

  function automatic logic [7:0] round_fk(logic [7:0] x, logic [7:0] k);
    return {x[7:4] ^ round_f(x[3:0], k), x[3:0]};
  endfunction

  function automatic logic [7:0] sdes_core(logic [7:0] b, logic [7:0] ka, logic [7:0] kb);
    logic [7:0] x;
    x = perm_ip(b);
    x = round_fk(x, ka);
    x = {x[3:0], x[7:4]};
    x = round_fk(x, kb);
    return perm_ipi(x);
  endfunction

endpackage

/* hdl/sdes_stream_if.sv */
// valid/ready channel carrying one payload per transaction
interface sdes_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/simplified_des_cipher.sv */
// simplified des byte cipher with optional cipher-block chaining
// path: an accepted input is held in the input register, then in the result register,
//   which drives the output; a blocked output can stall both
// throughput: one byte per clock unless out_o stalls; chain_q holds the chaining value
// reset: rst_ni clears key, init vector, chain enable, chaining value and valid flags
module simplified_des_cipher (
  input logic              clk_i,
  input logic              rst_ni,
  sdes_stream_if.sink      cfg_i,
  sdes_stream_if.sink      in_i,
  sdes_stream_if.source    out_o
);
  import sdes_pkg::*;

  logic [KeyWidth-1:0]  key_q;
  logic [ByteWidth-1:0] iv_q;
  logic                 chain_en_q;
  logic [ByteWidth-1:0] chain_q, chain_d;

  logic                 s1_valid_q;
  in_item_t             s1_item_q;
  logic                 out_valid_q;
  out_item_t            out_q, out_d;

  logic                 out_free, s1_adv, in_accept;
  logic [7:0]           k1, k2;
  logic [ByteWidth-1:0] chain_base, mix;

  cfg_item_t cfg_item;
  in_item_t  in_item;

  assign cfg_item    = cfg_i.data;
  assign in_item     = in_i.data;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      iv_q       <= '0;
      chain_en_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_item.index)
        REG_CIPHER_KEY:   key_q      <= cfg_item.value;
        REG_INIT_VECTOR:  iv_q       <= cfg_item.value[ByteWidth-1:0];
        REG_CHAIN_ENABLE: chain_en_q <= cfg_item.value[0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_accept  = in_i.valid && in_i.ready;

  assign k1 = subkey1(key_q);
  assign k2 = subkey2(key_q);

  always_comb begin
    chain_base = s1_item_q.message_start ? iv_q : chain_q;
    mix        = chain_en_q ? chain_base : '0;
    if (s1_item_q.kind == KIND_DECRYPT) begin
      out_d.result_byte = sdes_core(s1_item_q.data_byte, k2, k1) ^ mix;
      chain_d           = s1_item_q.data_byte;
    end else begin
      out_d.result_byte = sdes_core(s1_item_q.data_byte ^ mix, k1, k2);
      chain_d           = out_d.result_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        chain_q <= chain_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a held input");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while both stages are blocked");

  a_dec_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_item_q.kind == KIND_DECRYPT) |=> chain_q == $past(s1_item_q.data_byte))
    else $error("chaining value not loaded from decrypt input");

  a_enc_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_item_q.kind == KIND_ENCRYPT) |=> chain_q == out_q.result_byte)
    else $error("chaining value differs from encrypt result");

endmodule
